/* design/van_leer_limited_advection_stencil_defines.svh */
// Assertion macros for the advection stencil.
`ifndef VAN_LEER_LIMITED_ADVECTION_STENCIL_DEFINES_SVH
`define VAN_LEER_LIMITED_ADVECTION_STENCIL_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define VLAS_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define VLAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VLAS_ASSERT_HOLDS(label, clk, rst, ante, cons, msg)
`define VLAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* design/vlas_pkg.sv */
package vlas_pkg;

   // Default data format
   localparam int VALUE_WIDTH_DEF   = 32;
   localparam int FRACTION_BITS_DEF = 16;

   // Courant factor format, unsigned Q8.16
   localparam int COURANT_W    = 24;
   localparam int COURANT_FRAC = 16;

   // Register file
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = COURANT_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCHEME_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COURANT     = 1'd1;

   // Scheme codes
   localparam logic [1:0] MODE_UPWIND    = 2'd0;
   localparam logic [1:0] MODE_VAN_LEER  = 2'd1;
   localparam logic [1:0] MODE_CENTRAL   = 2'd2;
   localparam logic [1:0] MODE_NONE      = 2'd3;

   localparam logic [1:0]           MODE_RESET    = MODE_VAN_LEER;
   localparam logic [COURANT_W-1:0] COURANT_RESET = 24'd65536;

endpackage

/* design/van_leer_limited_advection_stencil.sv */
// Advection stencil: one request carries a cell's five temperatures along one axis, the
// velocity component and a solid flag; one response carries the saturated temperature
// increment -courant * velocity * D for that axis, D picked by scheme_mode (upwind, van
// Leer limited MUSCL, central, or none). A request is taken every cycle; the two limiter
// dividers resolve one quotient bit per pipeline stage. A stalled response holds the whole
// pipe.
`include "van_leer_limited_advection_stencil_defines.svh"

module van_leer_limited_advection_stencil #(
   parameter int VALUE_WIDTH   = vlas_pkg::VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = vlas_pkg::FRACTION_BITS_DEF,
   localparam int REQ_DATA_W   = ((6 * VALUE_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // temp_far_minus, temp_minus, temp_center, temp_plus, temp_far_plus, velocity
   input  logic [REQ_DATA_W-1:0]               req_tdata,
   // solid_cell
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // temp_increment
   output logic [RSP_DATA_W-1:0]               rsp_tdata,
   // saturated
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_wr_en,
   input  logic [vlas_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vlas_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int W    = VALUE_WIDTH;
   localparam int DW   = W + 1;            // neighbor differences
   localparam int BW   = W + 2;            // limiter denominator and remainder
   localparam int QW   = W + 1;            // limiter quotient
   localparam int NW   = 2 * DW;           // limiter numerator
   localparam int FW   = W + 2;            // face values
   localparam int DFW  = W + 3;            // scheme difference
   localparam int VCW  = vlas_pkg::COURANT_W + W;
   localparam int LO_W = VCW / 2;
   localparam int HI_W = VCW - LO_W;
   localparam int PW   = DFW + VCW;
   localparam int SH   = vlas_pkg::COURANT_FRAC + FRACTION_BITS;

   typedef struct packed {
      logic                    zero_out;
      logic [1:0]              mode;
      logic                    fwd;
      logic                    vneg;
      logic signed [W-1:0]     base_p;
      logic signed [W-1:0]     base_m;
      logic signed [DW-1:0]    alt_diff;
      logic [VCW-1:0]          vc;
   } side_type;

   // Configuration registers
   logic [1:0]                          mode_ff;
   logic [vlas_pkg::COURANT_W-1:0]      courant_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= vlas_pkg::MODE_RESET;
         courant_ff <= vlas_pkg::COURANT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            vlas_pkg::CSR_SCHEME_MODE: mode_ff    <= csr_wdata[1:0];
            vlas_pkg::CSR_COURANT:     courant_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Whole pipe advances unless the response is stalled
   logic adv;
   logic out_valid_ff;
   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Stage 1: unpack, differences, upwind side selection
   logic signed [W-1:0]  t_fm, t_m, t_c, t_p, t_fp, vel;
   logic signed [DW-1:0] dm, dp, dmm, dpp;
   logic                 fwd;
   side_type             side1_in, side1_ff;
   logic signed [DW-1:0] ap_in, dp_in, am_in, dmn_in;
   logic signed [DW-1:0] ap_ff, dp_ff, am_ff, dmn_ff;
   logic signed [W-1:0]  vel_ff;
   logic                 v1_ff;

   always_comb begin
      t_fm = $signed(req_tdata[0*W +: W]);
      t_m  = $signed(req_tdata[1*W +: W]);
      t_c  = $signed(req_tdata[2*W +: W]);
      t_p  = $signed(req_tdata[3*W +: W]);
      t_fp = $signed(req_tdata[4*W +: W]);
      vel  = $signed(req_tdata[5*W +: W]);
      fwd  = !vel[W-1];
      dm   = DW'(t_c) - DW'(t_m);
      dp   = DW'(t_p) - DW'(t_c);
      dmm  = DW'(t_m) - DW'(t_fm);
      dpp  = DW'(t_fp) - DW'(t_p);
      ap_in  = fwd ? dm : dpp;
      dp_in  = dp;
      am_in  = fwd ? dmm : dp;
      dmn_in = dm;
      side1_in.zero_out = req_tuser[0] || (mode_ff == vlas_pkg::MODE_NONE);
      side1_in.mode     = mode_ff;
      side1_in.fwd      = fwd;
      side1_in.vneg     = vel[W-1];
      side1_in.base_p   = fwd ? t_c : t_p;
      side1_in.base_m   = fwd ? t_m : t_c;
      side1_in.alt_diff = (mode_ff == vlas_pkg::MODE_UPWIND) ? (fwd ? dm : dp)
                                                             : DW'(t_p) - DW'(t_m);
      side1_in.vc       = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff <= side1_in;
         ap_ff    <= ap_in;
         dp_ff    <= dp_in;
         am_ff    <= am_in;
         dmn_ff   <= dmn_in;
         vel_ff   <= vel;
      end
   end

   // Stage 2: limiter numerator and denominator, courant times speed
   logic [BW-1:0]  rem_ff  [2][QW+1];
   logic [QW-1:0]  low_ff  [2][QW+1];
   logic [BW-1:0]  den_ff  [2][QW+1];
   logic           take_ff [2][QW+1];
   logic           dneg_ff [2][QW+1];
   side_type       sided_ff [QW+1];
   logic           vd_ff    [QW+1];

   logic signed [DW-1:0] la [2];
   logic signed [DW-1:0] ld [2];
   logic signed [BW-1:0] lb [2];
   logic [DW-1:0]        la_mag [2];
   logic [DW-1:0]        ld_mag [2];
   logic [BW-1:0]        lb_mag [2];
   logic [NW-1:0]        lnum [2];
   logic                 ltake [2];
   logic [W-1:0]         vel_mag;
   side_type             side2_in;

   always_comb begin
      la[0] = ap_ff;
      ld[0] = dp_ff;
      la[1] = am_ff;
      ld[1] = dmn_ff;
      for (int l = 0; l < 2; l++) begin
         lb[l]     = BW'(ld[l]) + BW'(1);
         la_mag[l] = la[l][DW-1] ? (~la[l] + 1'b1) : la[l];
         ld_mag[l] = ld[l][DW-1] ? (~ld[l] + 1'b1) : ld[l];
         lb_mag[l] = lb[l][BW-1] ? (~lb[l] + 1'b1) : lb[l];
         lnum[l]   = la_mag[l] * ld_mag[l];
         ltake[l]  = (!la[l][DW-1] && (la[l] != '0) && !lb[l][BW-1])
                     || (la[l][DW-1] && lb[l][BW-1]);
      end
      vel_mag     = vel_ff[W-1] ? (~vel_ff + 1'b1) : vel_ff;
      side2_in    = side1_ff;
      side2_in.vc = courant_ff * vel_mag;
   end

   // Divider stages: one restoring step per stage
   logic [BW:0] div_trial [2][1:QW];
   logic        div_ge    [2][1:QW];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         for (int k = 1; k <= QW; k++) begin
            div_trial[l][k] = {rem_ff[l][k-1], low_ff[l][k-1][QW-1]};
            div_ge[l][k]    = div_trial[l][k] >= {1'b0, den_ff[l][k-1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            rem_ff[l][0]  <= BW'(lnum[l][NW-1:QW]);
            low_ff[l][0]  <= lnum[l][QW-1:0];
            den_ff[l][0]  <= BW'(la_mag[l]) + lb_mag[l];
            take_ff[l][0] <= ltake[l];
            dneg_ff[l][0] <= ld[l][DW-1];
            for (int k = 1; k <= QW; k++) begin
               rem_ff[l][k]  <= div_ge[l][k]
                                ? BW'(div_trial[l][k] - {1'b0, den_ff[l][k-1]})
                                : div_trial[l][k][BW-1:0];
               low_ff[l][k]  <= {low_ff[l][k-1][QW-2:0], div_ge[l][k]};
               den_ff[l][k]  <= den_ff[l][k-1];
               take_ff[l][k] <= take_ff[l][k-1];
               dneg_ff[l][k] <= dneg_ff[l][k-1];
            end
         end
         sided_ff[0] <= side2_in;
         for (int k = 1; k <= QW; k++) begin
            sided_ff[k] <= sided_ff[k-1];
         end
      end
   end

   // Stage F: face values
   logic signed [FW-1:0] hs [2];
   logic [FW-1:0]        hmag [2];
   logic signed [FW-1:0] fp_in, fm_in, fp_ff, fm_ff;
   side_type             sidef_ff;
   logic                 vf_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         hmag[l] = take_ff[l][QW] ? {1'b0, low_ff[l][QW]} : '0;
         hs[l]   = dneg_ff[l][QW] ? $signed(~hmag[l] + 1'b1) : $signed(hmag[l]);
      end
      fp_in = sided_ff[QW].fwd ? FW'(sided_ff[QW].base_p) + hs[0]
                               : FW'(sided_ff[QW].base_p) - hs[0];
      fm_in = sided_ff[QW].fwd ? FW'(sided_ff[QW].base_m) + hs[1]
                               : FW'(sided_ff[QW].base_m) - hs[1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fp_ff    <= fp_in;
         fm_ff    <= fm_in;
         sidef_ff <= sided_ff[QW];
      end
   end

   // Stage D: pick the scheme difference, take its magnitude
   logic signed [DFW-1:0] diff;
   logic [DFW-1:0]        dmag_ff;
   logic                  pneg_d_ff, central_d_ff, zero_d_ff, vd2_ff;
   logic [VCW-1:0]        vc_d_ff;

   always_comb begin
      diff = (sidef_ff.mode == vlas_pkg::MODE_VAN_LEER) ? DFW'(fp_ff) - DFW'(fm_ff)
                                                       : DFW'(sidef_ff.alt_diff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dmag_ff      <= diff[DFW-1] ? (~diff + 1'b1) : diff;
         pneg_d_ff    <= sidef_ff.vneg ^ diff[DFW-1];
         central_d_ff <= sidef_ff.mode == vlas_pkg::MODE_CENTRAL;
         zero_d_ff    <= sidef_ff.zero_out;
         vc_d_ff      <= sidef_ff.vc;
      end
   end

   // Stage P1: partial products
   logic [DFW+LO_W-1:0] pp_lo_ff;
   logic [DFW+HI_W-1:0] pp_hi_ff;
   logic                pneg_p1_ff, central_p1_ff, zero_p1_ff, vp1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_lo_ff      <= dmag_ff * vc_d_ff[LO_W-1:0];
         pp_hi_ff      <= dmag_ff * vc_d_ff[VCW-1:LO_W];
         pneg_p1_ff    <= pneg_d_ff;
         central_p1_ff <= central_d_ff;
         zero_p1_ff    <= zero_d_ff;
      end
   end

   // Stage P2: sum partial products
   logic [PW-1:0] prod_ff;
   logic          pneg_p2_ff, central_p2_ff, zero_p2_ff, vp2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff       <= PW'(pp_lo_ff) + (PW'(pp_hi_ff) << LO_W);
         pneg_p2_ff    <= pneg_p1_ff;
         central_p2_ff <= central_p1_ff;
         zero_p2_ff    <= zero_p1_ff;
      end
   end

   // Stage R: round half away from zero on the magnitude
   logic [PW:0] half_n, half_c, sum_n, sum_c;
   logic [PW:0] q_ff;
   logic        pneg_r_ff, zero_r_ff, vr_ff;

   always_comb begin
      half_n = (PW + 1)'(1) << (SH - 1);
      half_c = (PW + 1)'(1) << SH;
      sum_n  = (PW + 1)'(prod_ff) + half_n;
      sum_c  = (PW + 1)'(prod_ff) + half_c;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff      <= central_p2_ff ? (sum_c >> (SH + 1)) : (sum_n >> SH);
         pneg_r_ff <= pneg_p2_ff;
         zero_r_ff <= zero_p2_ff;
      end
   end

   // Output stage: negate, clip, zero for solid or no-advection
   logic          res_neg, res_sat;
   logic [PW:0]   lim;
   logic [W-1:0]  res_mag, res_val;
   logic [W-1:0]  out_data_ff;
   logic          out_sat_ff;

   always_comb begin
      res_neg = !pneg_r_ff && (q_ff != '0);
      lim     = res_neg ? ((PW + 1)'(1) << (W - 1)) : (((PW + 1)'(1) << (W - 1)) - 1'b1);
      res_sat = q_ff > lim;
      res_mag = res_sat ? lim[W-1:0] : q_ff[W-1:0];
      res_val = res_neg ? (~res_mag + 1'b1) : res_mag;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= zero_r_ff ? '0 : res_val;
         out_sat_ff  <= !zero_r_ff && res_sat;
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         for (int k = 0; k <= QW; k++) begin
            vd_ff[k] <= 1'b0;
         end
         vf_ff        <= 1'b0;
         vd2_ff       <= 1'b0;
         vp1_ff       <= 1'b0;
         vp2_ff       <= 1'b0;
         vr_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_tvalid;
         vd_ff[0]     <= v1_ff;
         for (int k = 1; k <= QW; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
         vf_ff        <= vd_ff[QW];
         vd2_ff       <= vf_ff;
         vp1_ff       <= vd2_ff;
         vp2_ff       <= vp1_ff;
         vr_ff        <= vp2_ff;
         out_valid_ff <= vr_ff;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = RSP_DATA_W'(out_data_ff);
   assign rsp_tuser[0] = out_sat_ff;

   // Checks
   `VLAS_ASSERT_HOLDS(a_sat_at_bound, clock, reset, rsp_tvalid && rsp_tuser[0], (out_data_ff == {1'b0, {(W-1){1'b1}}}) || (out_data_ff == {1'b1, {(W-1){1'b0}}}), "saturated response not at a range bound")
   `VLAS_ASSERT_HOLDS(a_stall_blocks, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "request taken while response stalled")
   `VLAS_ASSERT_NEXT(a_zero_out, clock, reset, vr_ff && zero_r_ff && adv, rsp_tvalid && (out_data_ff == '0) && !out_sat_ff, "solid or no-advection item gave nonzero response")

endmodule
